[rtl/core/txdma_pkg.sv]
// ============================================================================
// Transmit ring DMA burst scheduler package
// Operation codes, beat types and reset constants shared by the ring logic.
// ============================================================================
`default_nettype none

package txdma_pkg;

    // Default ring depth in bytes
    localparam int RING_DEPTH_DEF = 256;

    // Stall limit after reset, in ticks
    localparam logic [15:0] STALL_LIMIT_RST = 16'd1000;

    typedef enum logic [1:0] {
        OP_PUSH       = 2'd0,
        OP_BURST_DONE = 2'd1,
        OP_FETCH      = 2'd2,
        OP_TICK       = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic        message_last;
        logic [7:0]  index;
    } t_in_beat;

    typedef struct packed {
        logic        accepted;
        logic        was_dropped;
        logic        burst_start;
        logic [7:0]  burst_addr;
        logic [8:0]  burst_length;
        logic [7:0]  fetched_byte;
        logic [8:0]  pending;
        logic        busy_res;
        logic [31:0] drop_count;
    } t_out_beat;

endpackage

`default_nettype wire

[rtl/core/tx_ring_dma_burst_scheduler.sv]
// ============================================================================
// Transmit ring DMA burst scheduler
// Byte ring with push, burst retire, DMA fetch and stall-timeout drop logic.
// ============================================================================
//
// One beat in, one beat out. Each input beat carries one operation: push a
// byte at the tail, retire the active DMA burst, fetch a ring byte for the
// DMA, or count one tick of stall time. The block takes one beat per clock
// whenever the output register is empty or is being drained in the same
// cycle; the result appears on the output in the cycle after the input
// beat is taken. A fetched byte is read from the ring memory: the byte store
// is a single synchronous RAM whose registered read port returns the byte
// in the cycle after the fetch is taken, and the result is held in the output
// register until it is taken. A push that finds the ring full is answered
// with accepted low and must be retried; ticks while it waits count toward
// stall_limit, after which the remainder of the current message is dropped
// and counted. After every operation an idle, non-empty ring launches a new
// burst at the head, at most up to the end of the ring. Fetching a ring
// position that was never written returns an undefined byte. The
// stall_limit register may be written only while no beat is in flight.
`default_nettype none

module tx_ring_dma_burst_scheduler #(
    parameter int RING_DEPTH = txdma_pkg::RING_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input operation channel
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  txdma_pkg::t_in_beat   i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output txdma_pkg::t_out_beat  o_out_data,
    // stall_limit register
    input  wire                   i_cfg_we,
    input  wire  [15:0]           i_cfg_wdata
);

    import txdma_pkg::*;

    // Ring position and fill widths follow the depth
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);

    localparam logic [AW-1:0] LAST_POS  = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_F   = FW'(RING_DEPTH);

    // Fetch index modulo depth: constant lookup over all byte-wide indexes
    function automatic logic [256*AW-1:0] idx_mod_table();
        logic [256*AW-1:0] tbl;
        tbl = '0;
        for (int v = 0; v < 256; v++) begin
            tbl[v*AW +: AW] = AW'(v % RING_DEPTH);
        end
        return tbl;
    endfunction

    localparam logic [256*AW-1:0] IDX_MOD = idx_mod_table();

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_blen, n_blen;
    logic          r_bactive, n_bactive;
    logic          r_wait, n_wait;
    logic [15:0]   r_ticks, n_ticks;
    logic          r_drop, n_drop;
    logic [31:0]   r_dropped, n_dropped;
    logic [15:0]   r_stall_limit;

    // Output register: result beat without the fetched byte, plus a flag
    // that selects the memory read data into it.
    logic          r_out_valid;
    t_out_beat     r_res, n_res;
    logic          r_is_fetch;

    // Ring memory and its registered read port
    logic [7:0]    r_ring [RING_DEPTH];
    logic [7:0]    r_rd_data;

    logic          w_accept;
    logic          w_store;
    logic [AW-1:0] w_rd_idx;

    // ------------------------------------------------------------------
    // Handshake: hold input while a finished result waits on a stalled
    // output; a result leaving this cycle frees the register for the next.
    // ------------------------------------------------------------------
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_data              = r_res;
        o_out_data.fetched_byte = r_is_fetch ? r_rd_data : 8'h00;
    end

    // ------------------------------------------------------------------
    // Fetch index modulo depth, taken from the constant table
    // ------------------------------------------------------------------
    assign w_rd_idx = IDX_MOD[int'(i_in_data.index) * AW +: AW];

    // ------------------------------------------------------------------
    // Operation and burst launch
    // ------------------------------------------------------------------
    always_comb begin
        logic [15:0]   ticks_inc;
        logic [FW-1:0] head_sum;
        logic [FW-1:0] room;
        logic [FW-1:0] len;
        logic [31:0]   head_ext;
        logic [31:0]   len_ext;
        logic [31:0]   fill_ext;

        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_blen    = r_blen;
        n_bactive = r_bactive;
        n_wait    = r_wait;
        n_ticks   = r_ticks;
        n_drop    = r_drop;
        n_dropped = r_dropped;
        w_store   = 1'b0;
        n_res     = '0;
        ticks_inc = (r_ticks != 16'hFFFF) ? r_ticks + 16'd1 : r_ticks;
        head_sum  = FW'(r_head) + r_blen;

        unique case (i_in_data.op)
            OP_PUSH: begin
                if (r_drop) begin
                    // discard the byte, count it, leave drop mode at message end
                    n_res.accepted    = 1'b1;
                    n_res.was_dropped = 1'b1;
                    if (r_dropped != 32'hFFFF_FFFF) begin
                        n_dropped = r_dropped + 32'd1;
                    end
                    if (i_in_data.message_last) begin
                        n_drop = 1'b0;
                    end
                end else if (r_fill < DEPTH_F) begin
                    w_store        = 1'b1;
                    n_tail         = (r_tail == LAST_POS) ? '0 : r_tail + AW'(1);
                    n_fill         = r_fill + FW'(1);
                    n_res.accepted = 1'b1;
                    n_wait         = 1'b0;
                    n_ticks        = '0;
                end else begin
                    // ring full: refuse and start waiting
                    if (!r_wait) begin
                        n_ticks = '0;
                    end
                    n_wait = 1'b1;
                end
            end
            OP_BURST_DONE: begin
                if (r_bactive) begin
                    n_fill    = (r_fill >= r_blen) ? r_fill - r_blen : '0;
                    n_head    = (head_sum == DEPTH_F) ? '0 : AW'(head_sum);
                    n_blen    = '0;
                    n_bactive = 1'b0;
                end
            end
            OP_FETCH: begin
                // byte comes from the memory read port next cycle
            end
            OP_TICK: begin
                if (r_wait && !r_drop) begin
                    if (ticks_inc >= r_stall_limit) begin
                        n_drop  = 1'b1;
                        n_wait  = 1'b0;
                        n_ticks = '0;
                    end else begin
                        n_ticks = ticks_inc;
                    end
                end
            end
        endcase

        // Launch a burst from the head when idle and not empty
        room = DEPTH_F - FW'(n_head);
        len  = (n_fill < room) ? n_fill : room;
        if (!n_bactive && n_fill != '0) begin
            n_bactive          = 1'b1;
            n_blen             = len;
            head_ext           = 32'(n_head);
            len_ext            = 32'(len);
            n_res.burst_start  = 1'b1;
            n_res.burst_addr   = head_ext[7:0];
            n_res.burst_length = len_ext[8:0];
        end else begin
            head_ext = '0;
            len_ext  = '0;
        end

        fill_ext         = 32'(n_fill);
        n_res.pending    = fill_ext[8:0];
        n_res.busy_res   = n_bactive || (n_fill != '0);
        n_res.drop_count = n_dropped;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_blen        <= '0;
            r_bactive     <= 1'b0;
            r_wait        <= 1'b0;
            r_ticks       <= '0;
            r_drop        <= 1'b0;
            r_dropped     <= '0;
            r_stall_limit <= STALL_LIMIT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stall_limit <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_fill    <= n_fill;
                r_blen    <= n_blen;
                r_bactive <= n_bactive;
                r_wait    <= n_wait;
                r_ticks   <= n_ticks;
                r_drop    <= n_drop;
                r_dropped <= n_dropped;
            end
            // fill on accept, drain when taken
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load with the beat, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res      <= n_res;
            r_is_fetch <= (i_in_data.op == OP_FETCH);
        end
    end

    // ------------------------------------------------------------------
    // Ring memory: write at the tail on a stored push, read on a fetch.
    // Writes and reads come from different beats, so they never meet at
    // the same edge and need no forwarding.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept && w_store) begin
            r_ring[r_tail] <= i_in_data.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.op == OP_FETCH) begin
            r_rd_data <= r_ring[w_rd_idx];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_F)
        else $error("fill level exceeds ring depth");

    a_burst_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bactive |-> (r_blen != '0) && (r_blen <= r_fill)
                      && (32'(r_head) + 32'(r_blen) <= 32'(RING_DEPTH)))
        else $error("active burst is empty, overfilled or wraps the ring");

    a_idle_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_bactive |-> (r_blen == '0) && (r_fill == '0))
        else $error("idle ring holds bytes or a burst length");

    a_wait_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wait && r_drop))
        else $error("waiting push while in drop mode");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Transmit ring DMA burst scheduler testbench
// Sends operation beats (push, burst done, fetch, tick) through the input
// channel. A shadow of the byte ring, burst state, stall timer and drop
// counter predicts each result beat, and the result channel is checked
// against it field by field. Phases vary stall_limit and sender/receiver
// back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import txdma_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    // Clock, reset and DUT ports; every input starts at a known value
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    always #2 i_clk = ~i_clk;

    tx_ring_dma_burst_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Operation beats still to be sent, and result beats still owed by the DUT
    t_in_beat  ops_q[$];
    t_out_beat ring_results_q[$];

    t_idle idle_mode = IDLE_NONE;
    int    errors = 0;
    int    msg_left = 0;

    // ------------------------------------------------------------------
    // Shadow of the ring: byte store, pointers, burst and stall state
    // ------------------------------------------------------------------
    logic [7:0]  ring_mem [DEPTH];
    bit          ring_written [DEPTH];
    logic [7:0]  hd_pos = '0;
    logic [7:0]  tl_pos = '0;
    logic [8:0]  fill = '0;
    logic [8:0]  burst_len = '0;
    logic        burst_on = 1'b0;
    logic        push_wait = 1'b0;
    logic [15:0] stall_cnt = '0;
    logic        dropping = 1'b0;
    logic [31:0] drop_total = '0;
    logic [15:0] stall_lim = STALL_LIMIT_RST;

    // Apply one operation to the shadow ring and return the result beat it owes
    function automatic t_out_beat predict_ring_op(input t_in_beat b);
        t_out_beat  r;
        logic [8:0] room;
        r = '0;
        case (b.op)
            OP_PUSH: begin
                if (dropping) begin
                    // drop mode: swallow the byte, end the mode on message end
                    r.accepted = 1'b1;
                    r.was_dropped = 1'b1;
                    if (drop_total != 32'hFFFF_FFFF)
                        drop_total++;
                    if (b.message_last)
                        dropping = 1'b0;
                end else if (fill < DEPTH) begin
                    ring_mem[tl_pos] = b.data;
                    ring_written[tl_pos] = 1'b1;
                    tl_pos++;
                    fill++;
                    r.accepted = 1'b1;
                    push_wait = 1'b0;
                    stall_cnt = '0;
                end else begin
                    // ring full: refuse, start the stall timer on the first refusal
                    if (!push_wait)
                        stall_cnt = '0;
                    push_wait = 1'b1;
                end
            end
            OP_BURST_DONE: begin
                if (burst_on) begin
                    fill = (fill >= burst_len) ? fill - burst_len : '0;
                    hd_pos = 8'(hd_pos + burst_len);
                    burst_len = '0;
                    burst_on = 1'b0;
                end
            end
            OP_FETCH: begin
                r.fetched_byte = ring_mem[b.index];
            end
            default: begin
                if (push_wait && !dropping) begin
                    if (stall_cnt != 16'hFFFF)
                        stall_cnt++;
                    if (stall_cnt >= stall_lim) begin
                        dropping = 1'b1;
                        push_wait = 1'b0;
                        stall_cnt = '0;
                    end
                end
            end
        endcase
        // An idle, non-empty ring launches a burst up to the ring end
        if (!burst_on && fill != 0) begin
            room = 9'd256 - hd_pos;
            burst_len = (fill < room) ? fill : room;
            burst_on = 1'b1;
            r.burst_start = 1'b1;
            r.burst_addr = hd_pos;
            r.burst_length = burst_len;
        end
        r.pending = fill;
        r.busy_res = burst_on || (fill != 0);
        r.drop_count = drop_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: take beats from ops_q, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ops
        t_in_beat   nxt;
        logic [7:0] p;
        int         gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 56 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        if (i_rst_n) begin
            // Predict on acceptance, so the shadow matches what the DUT has seen
            if (i_in_valid && !o_in_stall)
                ring_results_q.push_back(predict_ring_op(i_in_data));
            // Hold a stalled beat; otherwise offer the next one or go idle
            if (!(i_in_valid && o_in_stall)) begin
                if (ops_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    nxt = ops_q.pop_front();
                    // Steer a fetch onto a ring entry that has been written
                    if (nxt.op == OP_FETCH && !ring_written[nxt.index]) begin
                        p = nxt.index;
                        repeat (DEPTH) begin
                            if (ring_written[p])
                                break;
                            p++;
                        end
                        nxt.index = p;
                    end
                    i_in_data <= nxt;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: drive receiver stall, check every accepted result beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        int        stall_pct;
        bit        bad;
        stall_pct = (idle_mode == IDLE_RECV) ? 56 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ring_results_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result beat %p", o_out_data);
                end else begin
                    want = ring_results_q.pop_front();
                    bad = (o_out_data.accepted     !== want.accepted)
                       || (o_out_data.was_dropped  !== want.was_dropped)
                       || (o_out_data.burst_start  !== want.burst_start)
                       || (o_out_data.burst_addr   !== want.burst_addr)
                       || (o_out_data.burst_length !== want.burst_length)
                       || (o_out_data.fetched_byte !== want.fetched_byte)
                       || (o_out_data.pending      !== want.pending)
                       || (o_out_data.busy_res     !== want.busy_res)
                       || (o_out_data.drop_count   !== want.drop_count);
                    if (bad) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result beat mismatch\n  expected %p\n  actual   %p",
                                     want, o_out_data);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_op(input t_op op, input logic [7:0] data, input logic last,
                          input logic [7:0] idx);
        t_in_beat b;
        b.op = op;
        b.data = data;
        b.message_last = last;
        b.index = idx;
        ops_q.push_back(b);
    endtask

    // Queue n random beats; pushes form messages, with some broken framing.
    // Percentages pick push, burst done and fetch; the rest are ticks.
    task automatic add_random_ops(input int n, input int p_push, input int p_done,
                                  input int p_fetch);
        t_in_beat b;
        int       roll;
        repeat (n) begin
            roll = $urandom_range(99);
            b.data = 8'($urandom);
            b.index = 8'($urandom);
            b.message_last = 1'($urandom);
            if (roll < p_push) begin
                b.op = OP_PUSH;
                if (msg_left == 0)
                    msg_left = $urandom_range(1, 24);
                msg_left--;
                b.message_last = (msg_left == 0);
                if ($urandom_range(19) == 0)
                    b.message_last = ~b.message_last;
            end else if (roll < p_push + p_done) begin
                b.op = OP_BURST_DONE;
            end else if (roll < p_push + p_done + p_fetch) begin
                b.op = OP_FETCH;
            end else begin
                b.op = OP_TICK;
            end
            ops_q.push_back(b);
        end
    endtask

    // Wait until every queued beat has gone in and every result has come back
    task automatic drain();
        while (ops_q.size() != 0 || i_in_valid || ring_results_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write stall_limit; only called with the block idle
    task automatic set_stall_limit(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        stall_lim = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle retire and tick first, then data extremes, fetches,
        // retire of live bursts and a retire with nothing active
        idle_mode = IDLE_NONE;
        add_op(OP_BURST_DONE, 8'h00, 1'b0, 8'h00);
        add_op(OP_TICK,       8'hFF, 1'b1, 8'hFF);
        add_op(OP_PUSH,       8'h00, 1'b0, 8'hFF);
        add_op(OP_PUSH,       8'hFF, 1'b1, 8'h00);
        add_op(OP_FETCH,      8'h00, 1'b0, 8'h00);
        add_op(OP_FETCH,      8'hFF, 1'b1, 8'h01);
        add_op(OP_FETCH,      8'h00, 1'b0, 8'hFF);
        add_op(OP_BURST_DONE, 8'h00, 1'b0, 8'h00);
        add_op(OP_TICK,       8'h00, 1'b0, 8'h00);
        add_op(OP_PUSH,       8'h5A, 1'b0, 8'hAA);
        add_op(OP_PUSH,       8'hA5, 1'b1, 8'h55);
        add_op(OP_BURST_DONE, 8'hFF, 1'b1, 8'hFF);
        add_op(OP_BURST_DONE, 8'h00, 1'b0, 8'h00);
        add_op(OP_BURST_DONE, 8'h00, 1'b0, 8'h00);
        add_op(OP_FETCH,      8'h00, 1'b0, 8'h02);
        add_op(OP_FETCH,      8'h00, 1'b0, 8'h03);
        add_op(OP_PUSH,       8'h80, 1'b1, 8'h7F);
        add_op(OP_PUSH,       8'h01, 1'b0, 8'h80);
        add_op(OP_TICK,       8'h00, 1'b0, 8'h00);
        add_op(OP_FETCH,      8'h00, 1'b0, 8'h04);
        add_op(OP_BURST_DONE, 8'h00, 1'b0, 8'h00);
        add_op(OP_PUSH,       8'h7F, 1'b1, 8'h00);
        drain();

        // Lowest limit: a single tick while a push waits starts drop mode.
        // The stretch without burst retires fills the ring so refusals and drops occur.
        set_stall_limit(16'd1);
        idle_mode = IDLE_SEND;
        add_random_ops(280, 40, 12, 20);
        add_random_ops(320, 80, 0, 8);
        drain();

        // Highest limit: a full ring refuses pushes but drop mode stays off
        set_stall_limit(16'hFFFF);
        idle_mode = IDLE_RECV;
        add_random_ops(200, 45, 15, 20);
        add_random_ops(320, 80, 0, 8);
        drain();

        set_stall_limit(16'd3);
        idle_mode = IDLE_BOTH;
        add_random_ops(200, 45, 12, 20);
        add_random_ops(320, 80, 0, 8);
        drain();

        set_stall_limit(16'($urandom_range(2, 40)));
        idle_mode = IDLE_NONE;
        add_random_ops(250, 50, 10, 20);
        drain();

        // Back to the reset value
        set_stall_limit(STALL_LIMIT_RST);
        idle_mode = IDLE_BOTH;
        add_random_ops(200, 45, 15, 20);
        drain();

        repeat (8) @(posedge i_clk);
        errors += ring_results_q.size();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/core/txdma_pkg.sv
rtl/core/tx_ring_dma_burst_scheduler.sv
dv/testbench.sv
